### hdl/cvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cvs_pkg;

  localparam int unsigned DATA_W    = 32;  // field width
  localparam int unsigned SPEED_W   = 31;  // unsigned magnitude outputs
  localparam int unsigned SQ_W      = 64;  // square / product width
  localparam int unsigned ROOT_W    = 32;  // root and quotient width
  localparam int unsigned REM_W     = 33;  // square-root remainder width
  localparam int unsigned NUM_W     = 65;  // rounded numerator width
  localparam int unsigned DEPTH     = 32;  // cells per chain, one bit each
  localparam int unsigned FRAC_BITS = 16;  // fraction bits of the Q format

  localparam logic [NUM_W-1:0] RVU_HALF = NUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [NUM_W-1:0] QUOT_OVF = NUM_W'(1) << ROOT_W;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
  } in_t;

  typedef struct packed {
    logic        [SPEED_W-1:0] speed;
    logic signed [DATA_W-1:0]  radial_speed;
    logic signed [DATA_W-1:0]  tangential_speed;
    logic        [SPEED_W-1:0] meridional_speed;
    logic signed [DATA_W-1:0]  radius_times_tangential;
    logic signed [DATA_W-1:0]  tan_vec_x;
    logic signed [DATA_W-1:0]  tan_vec_y;
    logic signed [DATA_W-1:0]  tan_vec_z;
    logic signed [DATA_W-1:0]  rad_vec_x;
    logic signed [DATA_W-1:0]  rad_vec_y;
    logic signed [DATA_W-1:0]  rad_vec_z;
    logic                      on_axis;
  } out_t;

  // square-root cell state: operand bits still to consume, remainder, root so far
  typedef struct packed {
    logic [SQ_W-1:0]   opnd;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // divider cell state: partial remainder, numerator/quotient shift word, divisor
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] num;
    logic [ROOT_W-1:0] den;
    logic              neg;
    logic              ovf;
  } div_st_t;

  function automatic logic [DATA_W-1:0] absu32(input logic signed [DATA_W-1:0] x);
    absu32 = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic neg,
                                                     input logic [NUM_W-1:0] mag);
    if (neg) begin
      if (mag >= (NUM_W'(1) << (DATA_W - 1))) begin
        sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat32 = -$signed(mag[DATA_W-1:0]);
      end
    end else begin
      if (mag > NUM_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
        sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        sat32 = $signed(mag[DATA_W-1:0]);
      end
    end
  endfunction

  function automatic logic [SPEED_W-1:0] satu31(input logic [ROOT_W:0] x);
    satu31 = (x > (ROOT_W+1)'({SPEED_W{1'b1}})) ? {SPEED_W{1'b1}} : x[SPEED_W-1:0];
  endfunction

  // round to nearest: bump when remainder exceeds the floor root
  function automatic logic [ROOT_W:0] round_root(input sqrt_st_t st);
    round_root = {1'b0, st.root} + (ROOT_W+1)'(st.rem > {1'b0, st.root});
  endfunction

  function automatic div_st_t div_init(input logic [SQ_W-1:0] mag,
                                       input logic [ROOT_W-1:0] den,
                                       input logic neg);
    logic [NUM_W-1:0] n;
    div_st_t          st;
    n      = {1'b0, mag} + NUM_W'(den >> 1);
    st.rem = n[SQ_W-1:ROOT_W];
    st.num = n[ROOT_W-1:0];
    st.den = den;
    st.neg = neg;
    st.ovf = (n[NUM_W-1:ROOT_W] >= {1'b0, den});
    div_init = st;
  endfunction

  function automatic logic [NUM_W-1:0] quot_mag(input div_st_t st);
    quot_mag = st.ovf ? QUOT_OVF : NUM_W'(st.num);
  endfunction

endpackage

`default_nettype wire

### hdl/cvs_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cvs_sqrt_cell
  import cvs_pkg::*;
#(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire sqrt_st_t         st_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output sqrt_st_t              st_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic [REM_W+1:0] t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  logic             valid_q;
  sqrt_st_t         st_d, st_q;
  logic [TAG_W-1:0] tag_q;

  // one restoring step: bring down two operand bits, try (4*root + 1)
  always_comb begin
    t       = {st_i.rem, st_i.opnd[SQ_W-1 -: 2]};
    trial   = {1'b0, st_i.root, 2'b01};
    ge      = (t >= trial);
    diff    = t - trial;
    st_d.rem  = ge ? diff[REM_W-1:0] : t[REM_W-1:0];
    st_d.root = {st_i.root[ROOT_W-2:0], ge};
    st_d.opnd = {st_i.opnd[SQ_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q  <= st_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

### hdl/cvs_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cvs_div_cell
  import cvs_pkg::*;
#(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire div_st_t          st_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output div_st_t               st_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic [ROOT_W:0]  t;
  logic [ROOT_W:0]  diff;
  logic             ge;
  logic             valid_q;
  div_st_t          st_d, st_q;
  logic [TAG_W-1:0] tag_q;

  // one restoring step; the quotient bit shifts in where the numerator bit left
  always_comb begin
    t       = {st_i.rem, st_i.num[ROOT_W-1]};
    ge      = (t >= {1'b0, st_i.den});
    diff    = t - {1'b0, st_i.den};
    st_d     = st_i;
    st_d.rem = ge ? diff[ROOT_W-1:0] : t[ROOT_W-1:0];
    st_d.num = {st_i.num[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q  <= st_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

### hdl/cvs_sqrt_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module cvs_sqrt_chain
  import cvs_pkg::*;
#(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire logic [SQ_W-1:0]  opnd_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output sqrt_st_t              st_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic             vld [DEPTH+1];
  sqrt_st_t         st  [DEPTH+1];
  logic [TAG_W-1:0] tag [DEPTH+1];

  assign vld[0]     = valid_i;
  assign st[0].opnd = opnd_i;
  assign st[0].rem  = '0;
  assign st[0].root = '0;
  assign tag[0]     = tag_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cvs_sqrt_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (vld[k]),
      .st_i    (st[k]),
      .tag_i   (tag[k]),
      .valid_o (vld[k+1]),
      .st_o    (st[k+1]),
      .tag_o   (tag[k+1])
    );
  end

  assign valid_o = vld[DEPTH];
  assign st_o    = st[DEPTH];
  assign tag_o   = tag[DEPTH];

endmodule

`default_nettype wire

### hdl/cvs_div_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module cvs_div_chain
  import cvs_pkg::*;
#(
  parameter int unsigned TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire div_st_t          st_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output div_st_t               st_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic             vld [DEPTH+1];
  div_st_t          st  [DEPTH+1];
  logic [TAG_W-1:0] tag [DEPTH+1];

  assign vld[0] = valid_i;
  assign st[0]  = st_i;
  assign tag[0] = tag_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cvs_div_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (vld[k]),
      .st_i    (st[k]),
      .tag_i   (tag[k]),
      .valid_o (vld[k+1]),
      .st_o    (st[k+1]),
      .tag_o   (tag[k+1])
    );
  end

  assign valid_o = vld[DEPTH];
  assign st_o    = st[DEPTH];
  assign tag_o   = tag[DEPTH];

endmodule

`default_nettype wire

### hdl/cylindrical_velocity_split.sv
`timescale 1ns / 1ps
`default_nettype none

// Cylindrical velocity split. Each request carries one point (position and
// velocity, signed Q16.16); the block returns speed, radial and tangential
// speed, meridional speed, radius times tangential speed and the tangential
// and radial vectors about the axis chosen by the axis register (0 x, 1 y,
// 2 or 3 z). A point on the axis raises on_axis and zeroes the vectors.
// Throughput is one request per clock while the skid register is empty. The
// pipeline holds three chains of 32 one-bit cells: radius and speed square
// roots, then the two divisions by the radius, then the four vector divisions
// beside the meridional root. The whole pipeline advances together; a
// two-entry output buffer (output register plus skid register) keeps
// in_ready_o registered, and input is still taken while one finished result
// waits. The axis register may only be written while no request is in
// flight.

module cylindrical_velocity_split
  import cvs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o
);

  // tag widths for the side data riding along each chain
  localparam int unsigned TAG_RAD_W = 1 + SQ_W + 2*DATA_W;
  localparam int unsigned TAG_SPD_W = 1 + SQ_W + 3*DATA_W;
  localparam int unsigned TAG_DOT_W = DATA_W + SPEED_W + 2*DATA_W;
  localparam int unsigned TAG_CRS_W = 3*DATA_W;

  logic adv;
  logic [1:0] axis_q;

  // ---------------------------------------------------------------- axis reg
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= AXIS_Z;
    end else if (cfg_valid_i) begin
      axis_q <= cfg_data_i;
    end
  end

  // ------------------------------------------------ stage 1: permute, multiply
  logic signed [DATA_W-1:0] pa, pb, pu, pv, pw;

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        pa = in_data_i.pos_y; pb = in_data_i.pos_z;
        pu = in_data_i.vel_y; pv = in_data_i.vel_z; pw = in_data_i.vel_x;
      end
      AXIS_Y: begin
        pa = in_data_i.pos_z; pb = in_data_i.pos_x;
        pu = in_data_i.vel_z; pv = in_data_i.vel_x; pw = in_data_i.vel_y;
      end
      default: begin
        pa = in_data_i.pos_x; pb = in_data_i.pos_y;
        pu = in_data_i.vel_x; pv = in_data_i.vel_y; pw = in_data_i.vel_z;
      end
    endcase
  end

  logic                     s1_v_q;
  logic signed [DATA_W-1:0] s1_a_q, s1_b_q, s1_u_q, s1_v_pay_q, s1_w_q;
  logic [SQ_W-1:0]          s1_sqa_q, s1_sqb_q, s1_squ_q, s1_sqv_q, s1_sqw_q;
  logic signed [SQ_W-1:0]   s1_au_q, s1_bv_q, s1_av_q, s1_bu_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q     <= pa;
      s1_b_q     <= pb;
      s1_u_q     <= pu;
      s1_v_pay_q <= pv;
      s1_w_q     <= pw;
      s1_sqa_q   <= absu32(pa) * absu32(pa);
      s1_sqb_q   <= absu32(pb) * absu32(pb);
      s1_squ_q   <= absu32(pu) * absu32(pu);
      s1_sqv_q   <= absu32(pv) * absu32(pv);
      s1_sqw_q   <= absu32(pw) * absu32(pw);
      s1_au_q    <= pa * pu;
      s1_bv_q    <= pb * pv;
      s1_av_q    <= pa * pv;
      s1_bu_q    <= pb * pu;
    end
  end

  // ------------------------------------------------ stage 2: sums, dot, cross
  logic signed [SQ_W:0] dot_s, crs_s;
  logic [SQ_W-1:0]      dot_m, crs_m;

  always_comb begin
    dot_s = {s1_au_q[SQ_W-1], s1_au_q} + {s1_bv_q[SQ_W-1], s1_bv_q};
    crs_s = {s1_av_q[SQ_W-1], s1_av_q} - {s1_bu_q[SQ_W-1], s1_bu_q};
    dot_m = dot_s[SQ_W] ? SQ_W'(-dot_s) : dot_s[SQ_W-1:0];
    crs_m = crs_s[SQ_W] ? SQ_W'(-crs_s) : crs_s[SQ_W-1:0];
  end

  logic                     s2_v_q;
  logic [SQ_W-1:0]          s2_rsq_q, s2_ssq_q;
  logic [TAG_RAD_W-1:0]     s2_tag_rad_q;
  logic [TAG_SPD_W-1:0]     s2_tag_spd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_rsq_q     <= s1_sqa_q + s1_sqb_q;
      s2_ssq_q     <= s1_squ_q + s1_sqv_q + s1_sqw_q;
      s2_tag_rad_q <= {dot_s[SQ_W], dot_m, s1_a_q, s1_b_q};
      s2_tag_spd_q <= {crs_s[SQ_W], crs_m, s1_u_q, s1_v_pay_q, s1_w_q};
    end
  end

  // ------------------------------------------- radius and speed root chains
  logic                 ra_v, sa_v;
  sqrt_st_t             ra_st, sa_st;
  logic [TAG_RAD_W-1:0] ra_tag;
  logic [TAG_SPD_W-1:0] sa_tag;

  cvs_sqrt_chain #(.TAG_W(TAG_RAD_W)) u_rad_root (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s2_v_q), .opnd_i(s2_rsq_q), .tag_i(s2_tag_rad_q),
    .valid_o(ra_v), .st_o(ra_st), .tag_o(ra_tag)
  );

  cvs_sqrt_chain #(.TAG_W(TAG_SPD_W)) u_spd_root (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s2_v_q), .opnd_i(s2_ssq_q), .tag_i(s2_tag_spd_q),
    .valid_o(sa_v), .st_o(sa_st), .tag_o(sa_tag)
  );

  // ------------------------------------------------ stage 3: round the roots
  logic [ROOT_W:0] rad_rnd, spd_rnd;

  assign rad_rnd = round_root(ra_st);
  assign spd_rnd = round_root(sa_st);

  logic                     s3_v_q;
  logic [ROOT_W-1:0]        s3_rad_q;
  logic [SPEED_W-1:0]       s3_speed_q;
  logic                     s3_dneg_q, s3_cneg_q;
  logic [SQ_W-1:0]          s3_dmag_q, s3_cmag_q;
  logic signed [DATA_W-1:0] s3_a_q, s3_b_q, s3_u_q, s3_vv_q, s3_w_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // radius squared is at most 2^63, so the rounded root fits 32 bits
      s3_rad_q   <= rad_rnd[ROOT_W-1:0];
      s3_speed_q <= satu31(spd_rnd);
      s3_dneg_q  <= ra_tag[TAG_RAD_W-1];
      s3_dmag_q  <= ra_tag[TAG_RAD_W-2 -: SQ_W];
      s3_a_q     <= ra_tag[2*DATA_W-1 -: DATA_W];
      s3_b_q     <= ra_tag[DATA_W-1:0];
      s3_cneg_q  <= sa_tag[TAG_SPD_W-1];
      s3_cmag_q  <= sa_tag[TAG_SPD_W-2 -: SQ_W];
      s3_u_q     <= sa_tag[3*DATA_W-1 -: DATA_W];
      s3_vv_q    <= sa_tag[2*DATA_W-1 -: DATA_W];
      s3_w_q     <= sa_tag[DATA_W-1:0];
    end
  end

  // ---------------------------------- stage 4: rounded numerators, overflow
  logic                 s4_v_q;
  div_st_t              s4_dot_q, s4_crs_q;
  logic [TAG_DOT_W-1:0] s4_tag_dot_q;
  logic [TAG_CRS_W-1:0] s4_tag_crs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_dot_q     <= div_init(s3_dmag_q, s3_rad_q, s3_dneg_q);
      s4_crs_q     <= div_init(s3_cmag_q, s3_rad_q, s3_cneg_q);
      s4_tag_dot_q <= {s3_rad_q, s3_speed_q, s3_u_q, s3_w_q};
      s4_tag_crs_q <= {s3_a_q, s3_b_q, s3_vv_q};
    end
  end

  // ---------------------------------------- dot and cross division chains
  logic                 da_v, ca_v;
  div_st_t              da_st, ca_st;
  logic [TAG_DOT_W-1:0] da_tag;
  logic [TAG_CRS_W-1:0] ca_tag;

  cvs_div_chain #(.TAG_W(TAG_DOT_W)) u_dot_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s4_v_q), .st_i(s4_dot_q), .tag_i(s4_tag_dot_q),
    .valid_o(da_v), .st_o(da_st), .tag_o(da_tag)
  );

  cvs_div_chain #(.TAG_W(TAG_CRS_W)) u_crs_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s4_v_q), .st_i(s4_crs_q), .tag_i(s4_tag_crs_q),
    .valid_o(ca_v), .st_o(ca_st), .tag_o(ca_tag)
  );

  // --------------------------------- stage 5: radial and tangential speeds
  logic [ROOT_W-1:0]        t5_rad;
  logic signed [DATA_W-1:0] t5_u, t5_v;
  logic                     t5_axis0;
  logic signed [DATA_W-1:0] t5_vr, t5_vu;

  always_comb begin
    t5_rad   = da_tag[TAG_DOT_W-1 -: ROOT_W];
    t5_u     = da_tag[2*DATA_W-1 -: DATA_W];
    t5_v     = ca_tag[DATA_W-1:0];
    t5_axis0 = (t5_rad == '0);
    if (t5_axis0) begin
      // on the axis the point is taken to lie along +a
      t5_vr = sat32(!t5_u[DATA_W-1] && (t5_u != '0), NUM_W'(absu32(t5_u)));
      t5_vu = t5_v;
    end else begin
      // radial value is the negated dot quotient
      t5_vr = sat32(!da_st.neg, quot_mag(da_st));
      t5_vu = sat32(ca_st.neg, quot_mag(ca_st));
    end
  end

  logic                     s5_v_q;
  logic signed [DATA_W-1:0] s5_vr_q, s5_vu_q, s5_a_q, s5_b_q, s5_w_q;
  logic [ROOT_W-1:0]        s5_rad_q;
  logic [SPEED_W-1:0]       s5_speed_q;
  logic                     s5_axis0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_vr_q    <= t5_vr;
      s5_vu_q    <= t5_vu;
      s5_rad_q   <= t5_rad;
      s5_speed_q <= da_tag[TAG_DOT_W-ROOT_W-1 -: SPEED_W];
      s5_w_q     <= da_tag[DATA_W-1:0];
      s5_a_q     <= ca_tag[3*DATA_W-1 -: DATA_W];
      s5_b_q     <= ca_tag[2*DATA_W-1 -: DATA_W];
      s5_axis0_q <= t5_axis0;
    end
  end

  // ------------------------------------------------ stage 6: second products
  logic                     s6_v_q;
  logic [SQ_W-1:0]          s6_ptc1_q, s6_ptc2_q, s6_prc1_q, s6_prc2_q, s6_prvu_q;
  logic [SQ_W-1:0]          s6_sqw_q, s6_sqvr_q;
  logic                     s6_ntc1_q, s6_ntc2_q, s6_nrc1_q, s6_nrc2_q;
  logic signed [DATA_W-1:0] s6_vr_q, s6_vu_q;
  logic [ROOT_W-1:0]        s6_rad_q;
  logic [SPEED_W-1:0]       s6_speed_q;
  logic                     s6_axis0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_ptc1_q  <= absu32(s5_vu_q) * absu32(s5_b_q);
      s6_ptc2_q  <= absu32(s5_vu_q) * absu32(s5_a_q);
      s6_prc1_q  <= absu32(s5_vr_q) * absu32(s5_a_q);
      s6_prc2_q  <= absu32(s5_vr_q) * absu32(s5_b_q);
      s6_prvu_q  <= s5_rad_q * absu32(s5_vu_q);
      s6_sqw_q   <= absu32(s5_w_q) * absu32(s5_w_q);
      s6_sqvr_q  <= absu32(s5_vr_q) * absu32(s5_vr_q);
      // tangential c1 uses -b: negative exactly when b is positive
      s6_ntc1_q  <= s5_vu_q[DATA_W-1] != (!s5_b_q[DATA_W-1] && (s5_b_q != '0));
      s6_ntc2_q  <= s5_vu_q[DATA_W-1] != s5_a_q[DATA_W-1];
      s6_nrc1_q  <= s5_vr_q[DATA_W-1] != s5_a_q[DATA_W-1];
      s6_nrc2_q  <= s5_vr_q[DATA_W-1] != s5_b_q[DATA_W-1];
      s6_vr_q    <= s5_vr_q;
      s6_vu_q    <= s5_vu_q;
      s6_rad_q   <= s5_rad_q;
      s6_speed_q <= s5_speed_q;
      s6_axis0_q <= s5_axis0_q;
    end
  end

  // ----------------------------- stage 7: numerators, r*vu, meridional square
  logic [NUM_W-1:0] rvu_sum;

  assign rvu_sum = {1'b0, s6_prvu_q} + RVU_HALF;

  logic                     s7_v_q;
  logic [SQ_W-1:0]          s7_vmsq_q;
  div_st_t                  s7_tc1_q, s7_tc2_q, s7_rc1_q, s7_rc2_q;
  logic signed [DATA_W-1:0] s7_vr_q, s7_vu_q, s7_rvu_q;
  logic [SPEED_W-1:0]       s7_speed_q;
  logic                     s7_axis0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_vmsq_q  <= s6_sqw_q + s6_sqvr_q;
      s7_tc1_q   <= div_init(s6_ptc1_q, s6_rad_q, s6_ntc1_q);
      s7_tc2_q   <= div_init(s6_ptc2_q, s6_rad_q, s6_ntc2_q);
      s7_rc1_q   <= div_init(s6_prc1_q, s6_rad_q, s6_nrc1_q);
      s7_rc2_q   <= div_init(s6_prc2_q, s6_rad_q, s6_nrc2_q);
      s7_rvu_q   <= sat32(s6_vu_q[DATA_W-1], rvu_sum >> FRAC_BITS);
      s7_vr_q    <= s6_vr_q;
      s7_vu_q    <= s6_vu_q;
      s7_speed_q <= s6_speed_q;
      s7_axis0_q <= s6_axis0_q;
    end
  end

  // ------------------------- meridional root beside the four vector dividers
  logic               vm_v, tc1_v, tc2_v, rc1_v, rc2_v;
  sqrt_st_t           vm_st;
  div_st_t            tc1_st, tc2_st, rc1_st, rc2_st;
  logic [SPEED_W-1:0] vm_tag;
  logic [DATA_W-1:0]  tc1_tag, tc2_tag, rc1_tag;
  logic               rc2_tag;

  cvs_sqrt_chain #(.TAG_W(SPEED_W)) u_mer_root (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s7_v_q), .opnd_i(s7_vmsq_q), .tag_i(s7_speed_q),
    .valid_o(vm_v), .st_o(vm_st), .tag_o(vm_tag)
  );

  cvs_div_chain #(.TAG_W(DATA_W)) u_tc1_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s7_v_q), .st_i(s7_tc1_q), .tag_i(s7_vr_q),
    .valid_o(tc1_v), .st_o(tc1_st), .tag_o(tc1_tag)
  );

  cvs_div_chain #(.TAG_W(DATA_W)) u_tc2_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s7_v_q), .st_i(s7_tc2_q), .tag_i(s7_vu_q),
    .valid_o(tc2_v), .st_o(tc2_st), .tag_o(tc2_tag)
  );

  cvs_div_chain #(.TAG_W(DATA_W)) u_rc1_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s7_v_q), .st_i(s7_rc1_q), .tag_i(s7_rvu_q),
    .valid_o(rc1_v), .st_o(rc1_st), .tag_o(rc1_tag)
  );

  cvs_div_chain #(.TAG_W(1)) u_rc2_div (
    .clk_i, .rst_ni, .adv_i(adv),
    .valid_i(s7_v_q), .st_i(s7_rc2_q), .tag_i(s7_axis0_q),
    .valid_o(rc2_v), .st_o(rc2_st), .tag_o(rc2_tag)
  );

  // ----------------------------- final: saturate, zero on axis, map to x/y/z
  logic                     fin_v;
  out_t                     fin;
  logic signed [DATA_W-1:0] tc1, tc2, rc1, rc2;

  assign fin_v = vm_v & tc1_v & tc2_v & rc1_v & rc2_v;

  always_comb begin
    if (rc2_tag) begin
      tc1 = '0; tc2 = '0; rc1 = '0; rc2 = '0;
    end else begin
      tc1 = sat32(tc1_st.neg, quot_mag(tc1_st));
      tc2 = sat32(tc2_st.neg, quot_mag(tc2_st));
      rc1 = sat32(rc1_st.neg, quot_mag(rc1_st));
      rc2 = sat32(rc2_st.neg, quot_mag(rc2_st));
    end
    fin.speed                   = vm_tag;
    fin.radial_speed            = tc1_tag;
    fin.tangential_speed        = tc2_tag;
    fin.meridional_speed        = satu31(round_root(vm_st));
    fin.radius_times_tangential = rc2_tag ? '0 : rc1_tag;
    fin.on_axis                 = rc2_tag;
    case (axis_q)
      AXIS_X: begin
        fin.tan_vec_x = '0;  fin.tan_vec_y = tc1; fin.tan_vec_z = tc2;
        fin.rad_vec_x = '0;  fin.rad_vec_y = rc1; fin.rad_vec_z = rc2;
      end
      AXIS_Y: begin
        fin.tan_vec_x = tc2; fin.tan_vec_y = '0;  fin.tan_vec_z = tc1;
        fin.rad_vec_x = rc2; fin.rad_vec_y = '0;  fin.rad_vec_z = rc1;
      end
      default: begin
        fin.tan_vec_x = tc1; fin.tan_vec_y = tc2; fin.tan_vec_z = '0;
        fin.rad_vec_x = rc1; fin.rad_vec_y = rc2; fin.rad_vec_z = '0;
      end
    endcase
  end

  // ------------------------------------- output register and skid register
  // Pipeline advances while the skid slot is empty; a result landing on a
  // stalled output register parks in the skid slot.
  logic out_v_q, skid_v_q;
  out_t out_q, skid_q;
  logic out_fire;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;
  assign out_fire   = out_v_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s5_v_q   <= 1'b0;
      s6_v_q   <= 1'b0;
      s7_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_q <= in_valid_i;
        s2_v_q <= s1_v_q;
        s3_v_q <= ra_v & sa_v;
        s4_v_q <= s3_v_q;
        s5_v_q <= da_v & ca_v;
        s6_v_q <= s5_v_q;
        s7_v_q <= s6_v_q;
        if (fin_v) begin
          if (!out_v_q || out_fire) begin
            out_v_q <= 1'b1;
          end else begin
            skid_v_q <= 1'b1;
          end
        end else if (out_fire) begin
          out_v_q <= 1'b0;
        end
      end else if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (fin_v) begin
        if (!out_v_q || out_fire) begin
          out_q <= fin;
        end else begin
          skid_q <= fin;
        end
      end
    end else if (out_fire) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------- assertions
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a request while output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  a_axis_zero_vec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.on_axis) |->
      (out_q.tan_vec_x == '0 && out_q.tan_vec_y == '0 && out_q.tan_vec_z == '0 &&
       out_q.rad_vec_x == '0 && out_q.rad_vec_y == '0 && out_q.rad_vec_z == '0 &&
       out_q.radius_times_tangential == '0))
    else $error("on-axis result carries non-zero vector outputs");

endmodule

`default_nettype wire
